// ----- rtl/core/scp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_pkg: shared types and constants of the split charge state controller
// Request and result layouts, mode codes, register map and fixed thresholds.
// ----------------------------------------------------------------------------
package scp_pkg;

    // APB register map: eight 32-bit registers at 4-byte spacing
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_TURN_ON_MV     = 3'd0,
        REG_TURN_OFF_MV    = 3'd1,
        REG_DISCONNECT_MS  = 3'd2,
        REG_FULL_CONFIRM   = 3'd3,
        REG_FULL_VOLT_MV   = 3'd4,
        REG_FULL_CURR_MA   = 3'd5,
        REG_OVER_TEMP_DC   = 3'd6,
        REG_BATT_OVER_MV   = 3'd7
    } t_cfg_reg;

    // register reset values
    localparam logic        [14:0] TURN_ON_RST      = 15'd13400;
    localparam logic        [14:0] TURN_OFF_RST     = 15'd12800;
    localparam logic        [15:0] DISCONNECT_RST   = 16'd3000;
    localparam logic        [31:0] FULL_CONFIRM_RST = 32'd300000;
    localparam logic        [14:0] FULL_VOLT_RST    = 15'd14200;
    localparam logic signed [15:0] FULL_CURR_RST    = 16'sd500;
    localparam logic signed [11:0] OVER_TEMP_RST    = 12'sd600;
    localparam logic        [14:0] BATT_OVER_RST    = 15'd14600;

    // output mode codes
    typedef enum logic [1:0] {
        MODE_BULK    = 2'd0,
        MODE_FULL    = 2'd1,
        MODE_PROTECT = 2'd2,
        MODE_OFF     = 2'd3
    } t_mode;

    // charge state, one-hot
    typedef enum logic [3:0] {
        ST_BULK    = 4'b0001,
        ST_FULL    = 4'b0010,
        ST_PROTECT = 4'b0100,
        ST_OFF     = 4'b1000
    } t_charge_state;

    // fixed thresholds
    localparam logic signed [11:0] SENSOR_FAIL_DC  = -12'sd500;
    localparam logic signed [15:0] WARN_CURRENT_MA = 16'sd14000;
    localparam logic        [9:0]  WARN_HALF_MS    = 10'd500;
    localparam logic        [9:0]  WARN_ON_MS      = 10'd250;
    localparam logic        [10:0] ALARM_PERIOD_MS = 11'd1000;
    localparam logic        [9:0]  ALARM_BEEP1_END = 10'd100;
    localparam logic        [9:0]  ALARM_BEEP2_LO  = 10'd200;
    localparam logic        [9:0]  ALARM_BEEP2_HI  = 10'd300;
    localparam logic        [9:0]  ALARM_BEEP3_LO  = 10'd400;
    localparam logic        [9:0]  ALARM_BEEP3_HI  = 10'd500;
    localparam logic        [31:0] PULSE_GAP_MS    = 32'd1000;
    localparam logic        [31:0] AFTERRUN_MS     = 32'd30000;
    localparam logic        [3:0]  BEAT_LAST       = 4'd9;

    // residues of 2^10, 2^20 and 2^30 modulo 1000, for folding now_ms
    localparam logic [19:0] FOLD_10 = 20'd24;
    localparam logic [19:0] FOLD_20 = 20'd576;
    localparam logic [19:0] FOLD_30 = 20'd824;

    typedef struct packed {
        logic        [31:0] now_ms;
        logic        [14:0] alt_mv;
        logic        [14:0] batt_mv;
        logic signed [15:0] batt_ma;
        logic signed [11:0] temp_dc;
    } t_in_item;

    typedef struct packed {
        logic [1:0] mode;
        logic       relay_on;
        logic       buzzer;
        logic       watchdog_pulse;
        logic [3:0] beat_count;
    } t_out_item;

endpackage

// ----- rtl/core/split_charge_state_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// split_charge_state_controller: charge mode controller with hysteresis
// Per-sample protect, disconnect and full detection, buzzer and watchdog beat.
// ----------------------------------------------------------------------------
// Path: a request accepted into the input register moves on through the phase
// register and the result register; a stall can hold it in any of them.
// Throughput: one request per cycle while i_out_stall is low; the state update sits in a single stage.
// Reset: synchronous, active low; registers return to defaults, mode is off,
// timers unarmed, heartbeat zero. No clearing pass.

module split_charge_state_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample channel
    input  logic                              i_in_valid,
    input  scp_pkg::t_in_item                 i_in_data,
    output logic                              o_in_stall,
    // result channel
    output logic                              o_out_valid,
    output scp_pkg::t_out_item                o_out_data,
    input  logic                              i_out_stall,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [scp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [scp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [scp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    // configuration registers
    logic        [14:0] r_turn_on_mv;
    logic        [14:0] r_turn_off_mv;
    logic        [15:0] r_disconnect_ms;
    logic        [31:0] r_full_confirm_ms;
    logic        [14:0] r_full_volt_mv;
    logic signed [15:0] r_full_current_ma;
    logic signed [11:0] r_over_temp_dc;
    logic        [14:0] r_batt_over_mv;

    // pipeline
    logic                   r_in_vld;
    scp_pkg::t_in_item      r_in;
    logic                   r_mid_vld;
    scp_pkg::t_in_item      r_mid;
    logic [9:0]             r_mid_p1000;
    logic                   r_out_vld;
    scp_pkg::t_out_item     r_out;

    // controller state
    scp_pkg::t_charge_state r_mode;
    logic [31:0]            r_low_start_ms;
    logic [31:0]            r_full_start_ms;
    logic [31:0]            r_last_pulse_ms;
    logic [3:0]             r_heartbeat;

    logic out_rdy, mid_rdy, in_rdy, fire, cfg_we;
    scp_pkg::t_cfg_reg cfg_idx;

    // now_ms mod 1000 folding
    logic [19:0] fold1;
    logic [13:0] fold2;
    logic [10:0] fold3;
    logic [9:0]  n_p1000;

    // decision logic
    logic        protect, full_cond;
    logic [31:0] full_base, low_base, full_elapsed, low_elapsed;
    logic [31:0] afterrun_elapsed, pulse_elapsed;
    logic [9:0]  p500;
    logic        warn_on, alarm_on;
    scp_pkg::t_charge_state n_mode;
    logic [31:0] n_low_start_ms, n_full_start_ms, n_last_pulse_ms;
    logic [3:0]  n_heartbeat;
    logic        n_pulse, n_relay, n_buzz;
    logic [1:0]  n_mode_code;
    scp_pkg::t_out_item n_out;

    // ------------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------------
    assign out_rdy     = !r_out_vld || !i_out_stall;
    assign mid_rdy     = !r_mid_vld || out_rdy;
    assign in_rdy      = !r_in_vld || mid_rdy;
    assign fire        = r_mid_vld && out_rdy;
    assign o_in_stall  = !in_rdy;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_mid_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_rdy) begin
                r_in_vld <= i_in_valid;
            end
            if (mid_rdy) begin
                r_mid_vld <= r_in_vld;
            end
            if (out_rdy) begin
                r_out_vld <= r_mid_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_rdy && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (mid_rdy && r_in_vld) begin
            r_mid       <= r_in;
            r_mid_p1000 <= n_p1000;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    // ------------------------------------------------------------------------
    // phase within the one-second alarm period: fold 10-bit digits mod 1000
    // ------------------------------------------------------------------------
    assign fold1 = 20'(r_in.now_ms[9:0])
                 + 20'(r_in.now_ms[19:10]) * scp_pkg::FOLD_10
                 + 20'(r_in.now_ms[29:20]) * scp_pkg::FOLD_20
                 + 20'(r_in.now_ms[31:30]) * scp_pkg::FOLD_30;
    assign fold2 = 14'(fold1[9:0]) + 14'(fold1[19:10]) * 14'(scp_pkg::FOLD_10);
    assign fold3 = 11'(fold2[9:0]) + 11'(fold2[13:10]) * 11'(scp_pkg::FOLD_10);
    assign n_p1000 = (fold3 >= scp_pkg::ALARM_PERIOD_MS)
                   ? 10'(fold3 - scp_pkg::ALARM_PERIOD_MS) : fold3[9:0];

    // ------------------------------------------------------------------------
    // mode decision
    // ------------------------------------------------------------------------
    assign protect   = (r_mid.temp_dc > r_over_temp_dc)
                    || (r_mid.temp_dc < scp_pkg::SENSOR_FAIL_DC)
                    || (r_mid.batt_mv > r_batt_over_mv);
    assign full_cond = (r_mid.batt_mv > r_full_volt_mv)
                    && (r_mid.batt_ma < r_full_current_ma);

    // a zero start means unarmed: arm at this sample's time
    assign full_base    = (r_full_start_ms == '0) ? r_mid.now_ms : r_full_start_ms;
    assign low_base     = (r_low_start_ms == '0) ? r_mid.now_ms : r_low_start_ms;
    assign full_elapsed = r_mid.now_ms - full_base;
    assign low_elapsed  = r_mid.now_ms - low_base;

    always_comb begin
        n_mode          = r_mode;
        n_low_start_ms  = r_low_start_ms;
        n_full_start_ms = r_full_start_ms;
        if (protect) begin
            n_mode         = scp_pkg::ST_PROTECT;
            n_low_start_ms = '0;
        end else if (r_mid.alt_mv >= r_turn_on_mv) begin
            n_low_start_ms = '0;
            if (full_cond) begin
                n_full_start_ms = full_base;
                if (full_elapsed > r_full_confirm_ms) begin
                    n_mode = scp_pkg::ST_FULL;
                end
            end else begin
                n_full_start_ms = '0;
                // hold full while the battery stays above the floor
                if (!(r_mode == scp_pkg::ST_FULL && r_mid.batt_mv > r_turn_off_mv)) begin
                    n_mode = scp_pkg::ST_BULK;
                end
            end
        end else if (r_mid.alt_mv < r_turn_off_mv) begin
            n_low_start_ms = low_base;
            if (low_elapsed > {16'd0, r_disconnect_ms}) begin
                n_mode = scp_pkg::ST_OFF;
            end
        end else begin
            n_low_start_ms = '0;
        end
    end

    // ------------------------------------------------------------------------
    // relay, buzzer and watchdog beat
    // ------------------------------------------------------------------------
    assign p500     = (r_mid_p1000 >= scp_pkg::WARN_HALF_MS)
                    ? 10'(r_mid_p1000 - scp_pkg::WARN_HALF_MS) : r_mid_p1000;
    assign warn_on  = p500 < scp_pkg::WARN_ON_MS;
    assign alarm_on = (r_mid_p1000 < scp_pkg::ALARM_BEEP1_END)
                   || (r_mid_p1000 > scp_pkg::ALARM_BEEP2_LO
                       && r_mid_p1000 < scp_pkg::ALARM_BEEP2_HI)
                   || (r_mid_p1000 > scp_pkg::ALARM_BEEP3_LO
                       && r_mid_p1000 < scp_pkg::ALARM_BEEP3_HI);

    assign n_relay = (n_mode == scp_pkg::ST_BULK) || (n_mode == scp_pkg::ST_FULL);
    assign n_buzz  = ((n_mode == scp_pkg::ST_BULK)
                      && (r_mid.batt_ma > scp_pkg::WARN_CURRENT_MA) && warn_on)
                  || ((n_mode == scp_pkg::ST_PROTECT)
                      && (r_heartbeat == '0) && alarm_on);

    assign afterrun_elapsed = r_mid.now_ms - n_low_start_ms;
    assign pulse_elapsed    = r_mid.now_ms - r_last_pulse_ms;
    assign n_pulse = ((n_mode != scp_pkg::ST_OFF)
                      || (afterrun_elapsed < scp_pkg::AFTERRUN_MS))
                  && (pulse_elapsed > scp_pkg::PULSE_GAP_MS);

    assign n_last_pulse_ms = n_pulse ? r_mid.now_ms : r_last_pulse_ms;
    assign n_heartbeat     = !n_pulse ? r_heartbeat
                           : ((r_heartbeat >= scp_pkg::BEAT_LAST) ? '0 : r_heartbeat + 4'd1);

    always_comb begin
        case (n_mode)
            scp_pkg::ST_BULK:    n_mode_code = scp_pkg::MODE_BULK;
            scp_pkg::ST_FULL:    n_mode_code = scp_pkg::MODE_FULL;
            scp_pkg::ST_PROTECT: n_mode_code = scp_pkg::MODE_PROTECT;
            default:             n_mode_code = scp_pkg::MODE_OFF;
        endcase
    end

    always_comb begin
        n_out.mode           = n_mode_code;
        n_out.relay_on       = n_relay;
        n_out.buzzer         = n_buzz;
        n_out.watchdog_pulse = n_pulse;
        n_out.beat_count     = n_heartbeat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= scp_pkg::ST_OFF;
            r_low_start_ms  <= '0;
            r_full_start_ms <= '0;
            r_last_pulse_ms <= '0;
            r_heartbeat     <= '0;
        end else if (fire) begin
            r_mode          <= n_mode;
            r_low_start_ms  <= n_low_start_ms;
            r_full_start_ms <= n_full_start_ms;
            r_last_pulse_ms <= n_last_pulse_ms;
            r_heartbeat     <= n_heartbeat;
        end
    end

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = scp_pkg::t_cfg_reg'(paddr[scp_pkg::APB_ADDR_W-1:2]);
    assign cfg_we  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_on_mv      <= scp_pkg::TURN_ON_RST;
            r_turn_off_mv     <= scp_pkg::TURN_OFF_RST;
            r_disconnect_ms   <= scp_pkg::DISCONNECT_RST;
            r_full_confirm_ms <= scp_pkg::FULL_CONFIRM_RST;
            r_full_volt_mv    <= scp_pkg::FULL_VOLT_RST;
            r_full_current_ma <= scp_pkg::FULL_CURR_RST;
            r_over_temp_dc    <= scp_pkg::OVER_TEMP_RST;
            r_batt_over_mv    <= scp_pkg::BATT_OVER_RST;
        end else if (cfg_we) begin
            case (cfg_idx)
                scp_pkg::REG_TURN_ON_MV:    r_turn_on_mv      <= pwdata[14:0];
                scp_pkg::REG_TURN_OFF_MV:   r_turn_off_mv     <= pwdata[14:0];
                scp_pkg::REG_DISCONNECT_MS: r_disconnect_ms   <= pwdata[15:0];
                scp_pkg::REG_FULL_CONFIRM:  r_full_confirm_ms <= pwdata;
                scp_pkg::REG_FULL_VOLT_MV:  r_full_volt_mv    <= pwdata[14:0];
                scp_pkg::REG_FULL_CURR_MA:  r_full_current_ma <= pwdata[15:0];
                scp_pkg::REG_OVER_TEMP_DC:  r_over_temp_dc    <= pwdata[11:0];
                scp_pkg::REG_BATT_OVER_MV:  r_batt_over_mv    <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            scp_pkg::REG_TURN_ON_MV:    prdata = {17'd0, r_turn_on_mv};
            scp_pkg::REG_TURN_OFF_MV:   prdata = {17'd0, r_turn_off_mv};
            scp_pkg::REG_DISCONNECT_MS: prdata = {16'd0, r_disconnect_ms};
            scp_pkg::REG_FULL_CONFIRM:  prdata = r_full_confirm_ms;
            scp_pkg::REG_FULL_VOLT_MV:  prdata = {17'd0, r_full_volt_mv};
            scp_pkg::REG_FULL_CURR_MA:  prdata = {16'd0, r_full_current_ma};
            scp_pkg::REG_OVER_TEMP_DC:  prdata = {20'd0, r_over_temp_dc};
            scp_pkg::REG_BATT_OVER_MV:  prdata = {17'd0, r_batt_over_mv};
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_relay_matches_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.relay_on ==
            (o_out_data.mode == scp_pkg::MODE_BULK || o_out_data.mode == scp_pkg::MODE_FULL)))
        else $error("relay drive disagrees with mode");

    a_beat_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.beat_count <= scp_pkg::BEAT_LAST))
        else $error("heartbeat count out of range");

    a_buzz_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.buzzer) |->
            (o_out_data.mode == scp_pkg::MODE_BULK || o_out_data.mode == scp_pkg::MODE_PROTECT))
        else $error("buzzer active outside bulk or protect");

    a_protect_forced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && protect) |=> (r_out.mode == scp_pkg::MODE_PROTECT && !r_out.relay_on))
        else $error("fault did not force protect");

    a_pulse_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && n_pulse) |=> (r_last_pulse_ms == $past(r_mid.now_ms) && r_out.watchdog_pulse))
        else $error("watchdog pulse time not recorded");

endmodule
